// ----- rtl/afpd_pkg.sv -----
// Shared types and constants of the adaptive filter presence detector.
package afpd_pkg;

   // Item kinds carried by req_op.
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_POLL   = 1'b1
   } op_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GAIN_HIGH       = 3'd0;
   localparam logic [2:0] CSR_GAIN_LOW        = 3'd1;
   localparam logic [2:0] CSR_DISTANCE_MIN    = 3'd2;
   localparam logic [2:0] CSR_TRIGGER_OFFSET  = 3'd3;
   localparam logic [2:0] CSR_PULSE_TIME_MAX  = 3'd4;
   localparam logic [2:0] CSR_RISE_EXTRA_TIME = 3'd5;
   localparam logic [2:0] CSR_FALL_TIMEOUT    = 3'd6;

   localparam logic [15:0] GAIN_HIGH_RESET = 16'd36045;
   localparam logic [15:0] GAIN_LOW_RESET  = 16'd9830;

   // Samples below this value do not reach the filter.
   localparam logic [15:0] MIN_SAMPLE = 16'd100;

   // Gains are fractions over 2^GAIN_SHIFT.
   localparam int GAIN_SHIFT = 16;

   // Queue between front and back end.
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   typedef struct packed {
      logic [15:0] gain_high;
      logic [15:0] gain_low;
      logic [15:0] distance_min;
      logic [15:0] trigger_offset;
      logic [31:0] pulse_time_max;
      logic [31:0] rise_extra_time;
      logic [31:0] fall_timeout_default;
   } cfg_type;

   // One classified transaction as it waits in the queue.
   typedef struct packed {
      op_type      op;
      logic [15:0] sample;
      logic        last;
      logic [31:0] now_ms;
      logic [31:0] rise_to;
      logic [31:0] fall_to;
      logic [15:0] thr;
   } item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic pop;
      logic emit;
      logic busy;
   } bk_stat_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_ACC  = 1'b1
   } back_state_type;

endpackage

// ----- rtl/afpd_front.sv -----
// Front end: accept transactions and resolve timeouts and threshold.
module afpd_front (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [15:0]        req_sample,
   input  logic               req_last_sample,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_rise_timeout,
   input  logic [31:0]        req_fall_timeout,
   input  afpd_pkg::cfg_type  cfg,
   input  logic               q_full,
   output logic               push,
   output afpd_pkg::item_type item
);
   import afpd_pkg::*;

   logic use_default;

   assign req_ready   = !q_full;
   assign push        = req_valid && !q_full;
   // both timeouts zero select the configured defaults
   assign use_default = (req_rise_timeout == 32'd0) && (req_fall_timeout == 32'd0);

   always_comb begin
      item.op      = op_type'(req_op);
      item.sample  = req_sample;
      item.last    = req_last_sample;
      item.now_ms  = req_now_ms;
      item.rise_to = use_default ? (cfg.pulse_time_max + cfg.rise_extra_time)
                                 : req_rise_timeout;
      item.fall_to = use_default ? cfg.fall_timeout_default : req_fall_timeout;
      item.thr     = cfg.distance_min + cfg.trigger_offset;
   end

endmodule

// ----- rtl/afpd_queue.sv -----
// Small first-word-fall-through queue between front and back end.
module afpd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  afpd_pkg::item_type    push_item,
   input  logic                  pop,
   output afpd_pkg::item_type    head,
   output afpd_pkg::q_stat_type  stat
);
   import afpd_pkg::*;

   item_type         mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == (QAW+1)'(QDEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/afpd_back.sv -----
// Back end: filter multiply-accumulate, block level, detect timers, result register.
module afpd_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  afpd_pkg::cfg_type     cfg,
   input  afpd_pkg::item_type    head,
   input  logic                  head_valid,
   output afpd_pkg::bk_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_level,
   output logic                  rsp_detected
);
   import afpd_pkg::*;

   localparam int FW = 16 + FRAC_BITS;       // filter value width
   localparam int DW = FW + 1;               // signed difference
   localparam int PW = DW + 17;              // signed product
   localparam logic signed [DW-1:0] LIMIT = $signed(DW'(3) << (FRAC_BITS - 1));

   back_state_type          state_ff, state_in;

   logic [FW-1:0]           filter_ff, filter_in;
   logic                    bv_ff, bv_in;
   logic [15:0]             level_ff, level_in;
   logic                    detect_ff, detect_in;
   logic [31:0]             rise_start_ff, rise_start_in;
   logic                    rise_run_ff, rise_run_in;
   logic [31:0]             fall_start_ff, fall_start_in;
   logic                    fall_run_ff, fall_run_in;

   logic signed [PW-1:0]    prod_ff, prod_in;
   logic                    pass_ff;
   logic                    last_ff;

   logic                    rsp_valid_ff;
   logic [15:0]             rsp_level_ff;
   logic                    rsp_detected_ff;

   logic                    out_free;
   logic                    pop;
   logic                    emit;

   logic signed [DW-1:0]    diff;
   logic                    big_step;
   logic signed [16:0]      gain_s;
   logic signed [PW-1:0]    acc;
   logic [FW-1:0]           c_filter;
   logic                    c_bv;
   logic [15:0]             c_level;

   logic [31:0]             rs, fs, tr, tf, tr_run;
   logic                    p_detect, p_rise_run, p_fall_run;
   logic [31:0]             p_rise_start, p_fall_start;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Multiply stage: difference to the sample, gain choice, product.
   always_comb begin
      diff     = $signed({1'b0, head.sample, {FRAC_BITS{1'b0}}})
               - $signed({1'b0, filter_ff});
      big_step = (diff > LIMIT) || (diff < -LIMIT);
      gain_s   = $signed({1'b0, (big_step ? cfg.gain_high : cfg.gain_low)});
      prod_in  = PW'(diff) * PW'(gain_s);
   end

   // Accumulate stage: floor of product over 2^16, then close the block.
   always_comb begin
      acc      = $signed(PW'(filter_ff)) + (prod_ff >>> GAIN_SHIFT);
      c_filter = pass_ff ? acc[FW-1:0] : filter_ff;
      c_bv     = pass_ff || bv_ff;
      c_level  = level_ff;
      if (last_ff) begin
         c_level = c_bv ? c_filter[FRAC_BITS +: 16] : 16'd0;
         c_bv    = 1'b0;
      end
   end

   // Poll: threshold compare and the rise/fall debounce timers.
   always_comb begin
      rs           = rise_run_ff ? rise_start_ff : head.now_ms;
      fs           = fall_run_ff ? fall_start_ff : head.now_ms;
      tr           = head.now_ms - rs;
      tr_run       = head.now_ms - rise_start_ff;
      tf           = head.now_ms - fs;
      p_detect     = detect_ff;
      p_rise_start = 32'd0;
      p_rise_run   = 1'b0;
      p_fall_start = 32'd0;
      p_fall_run   = 1'b0;
      if (level_ff > head.thr) begin
         if (!detect_ff) begin
            if (tr >= head.rise_to) begin
               p_detect = 1'b1;
            end else begin
               p_rise_start = rs;
               p_rise_run   = 1'b1;
            end
         end
      end else if (rise_run_ff) begin
         if ((tf >= head.fall_to) || (tr_run >= head.rise_to)) begin
            p_detect = 1'b0;
         end else begin
            p_rise_start = rise_start_ff;
            p_rise_run   = 1'b1;
            p_fall_start = fs;
            p_fall_run   = 1'b1;
         end
      end else begin
         p_detect = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      filter_in     = filter_ff;
      bv_in         = bv_ff;
      level_in      = level_ff;
      detect_in     = detect_ff;
      rise_start_in = rise_start_ff;
      rise_run_in   = rise_run_ff;
      fall_start_in = fall_start_ff;
      fall_run_in   = fall_run_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               if (head.op == OP_POLL) begin
                  if (out_free) begin
                     pop           = 1'b1;
                     emit          = 1'b1;
                     detect_in     = p_detect;
                     rise_start_in = p_rise_start;
                     rise_run_in   = p_rise_run;
                     fall_start_in = p_fall_start;
                     fall_run_in   = p_fall_run;
                  end
               end else begin
                  pop      = 1'b1;
                  state_in = BK_ACC;
               end
            end
         end
         BK_ACC: begin
            if (out_free) begin
               emit      = 1'b1;
               filter_in = c_filter;
               bv_in     = c_bv;
               level_in  = c_level;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff     <= '0;
         bv_ff         <= 1'b0;
         level_ff      <= '0;
         detect_ff     <= 1'b0;
         rise_start_ff <= '0;
         rise_run_ff   <= 1'b0;
         fall_start_ff <= '0;
         fall_run_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         filter_ff     <= filter_in;
         bv_ff         <= bv_in;
         level_ff      <= level_in;
         detect_ff     <= detect_in;
         rise_start_ff <= rise_start_in;
         rise_run_ff   <= rise_run_in;
         fall_start_ff <= fall_start_in;
         fall_run_ff   <= fall_run_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (head.op == OP_SAMPLE)) begin
         prod_ff <= prod_in;
         pass_ff <= (head.sample >= MIN_SAMPLE);
         last_ff <= head.last;
      end
      if (emit) begin
         rsp_level_ff    <= level_in;
         rsp_detected_ff <= detect_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_detected = rsp_detected_ff;

   assign stat.pop  = pop;
   assign stat.emit = emit;
   assign stat.busy = (state_ff == BK_ACC);

endmodule

// ----- rtl/adaptive_filter_presence_detector.sv -----
// Top level of the adaptive filter presence detector.
//
// The block takes ADC sample transactions (req_op = 0) and detection polls
// (req_op = 1) and returns one result transaction for each: the current block
// level and the detect flag as they stand after that transaction. The front
// end accepts one transaction per cycle whenever the four-entry queue has room,
// resolves default timeouts and the detection threshold, and queues it. The
// back end takes one poll per cycle while its output register is free; a
// sample holds it until its accumulate commits, because the exponential
// filter recurrence runs through filter_ff with a registered multiply
// (difference times gain) followed by the accumulate. A poll's result passes
// the queue and the result register, a sample's also the product register.
// Results sit in an output register, so a stalled rsp_ready does not stop
// acceptance until the queue fills. Configuration writes on the csr_ port
// are always taken and apply to later transactions.
module adaptive_filter_presence_detector #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_sample,
   input  logic        req_last_sample,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_rise_timeout,
   input  logic [31:0] req_fall_timeout,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_level,
   output logic        rsp_detected
);
   import afpd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   item_type    push_item;
   item_type    head;
   logic        push;
   q_stat_type  q_stat;
   bk_stat_type bk_stat;

   // Configuration registers: always ready, index beyond the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_HIGH:       cfg_in.gain_high            = csr_data[15:0];
            CSR_GAIN_LOW:        cfg_in.gain_low             = csr_data[15:0];
            CSR_DISTANCE_MIN:    cfg_in.distance_min         = csr_data[15:0];
            CSR_TRIGGER_OFFSET:  cfg_in.trigger_offset       = csr_data[15:0];
            CSR_PULSE_TIME_MAX:  cfg_in.pulse_time_max       = csr_data;
            CSR_RISE_EXTRA_TIME: cfg_in.rise_extra_time      = csr_data;
            CSR_FALL_TIMEOUT:    cfg_in.fall_timeout_default = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_high            <= GAIN_HIGH_RESET;
         cfg_ff.gain_low             <= GAIN_LOW_RESET;
         cfg_ff.distance_min         <= '0;
         cfg_ff.trigger_offset       <= '0;
         cfg_ff.pulse_time_max       <= '0;
         cfg_ff.rise_extra_time      <= '0;
         cfg_ff.fall_timeout_default <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept and classify.
   afpd_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .req_now_ms       (req_now_ms),
      .req_rise_timeout (req_rise_timeout),
      .req_fall_timeout (req_fall_timeout),
      .cfg              (cfg_ff),
      .q_full           (q_stat.full),
      .push             (push),
      .item             (push_item)
   );

   // Queue: decouple acceptance from execution.
   afpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (bk_stat.pop),
      .head      (head),
      .stat      (q_stat)
   );

   // Back end: execute in order and hold the result.
   afpd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head         (head),
      .head_valid   (q_stat.valid),
      .stat         (bk_stat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_level    (rsp_level),
      .rsp_detected (rsp_detected)
   );

   // Never pop an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      bk_stat.pop |-> q_stat.valid)
      else $error("back end popped an empty queue");

   // Never overwrite a result that waits on a stalled response channel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !bk_stat.emit)
      else $error("result overwritten while stalled");

   // Hold the back end while a sample sits between multiply and accumulate.
   assert property (@(posedge clock) disable iff (reset)
      bk_stat.busy |-> !bk_stat.pop)
      else $error("queue popped during accumulate");

   assert property (@(posedge clock) disable iff (reset)
      (bk_stat.busy && !bk_stat.emit) |=> bk_stat.busy)
      else $error("accumulate dropped before commit");

endmodule

// ----- dv/adaptive_filter_presence_detector_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the adaptive filter presence detector.
module adaptive_filter_presence_detector_tb;
   import afpd_pkg::*;

   localparam int FRAC_BITS    = 16;
   localparam int AVG_W        = 16 + FRAC_BITS;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int PHASE_ITEMS  = 150;

   // One request transaction as offered on the req_ channel.
   typedef struct packed {
      op_type      op;
      logic [15:0] sample;
      logic        last;
      logic [31:0] now_ms;
      logic [31:0] rise_timeout;
      logic [31:0] fall_timeout;
   } req_txn_type;

   // One response transaction: block level and detect flag.
   typedef struct packed {
      logic [15:0] level;
      logic        detected;
   } presence_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index       = CSR_GAIN_HIGH;
   logic [31:0] csr_data        = '0;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_op          = OP_SAMPLE;
   logic [15:0] req_sample      = '0;
   logic        req_last_sample = 1'b0;
   logic [31:0] req_now_ms      = '0;
   logic [31:0] req_rise_timeout = '0;
   logic [31:0] req_fall_timeout = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [15:0] rsp_level;
   logic        rsp_detected;

   // Stimulus and scoreboard storage.
   req_txn_type  pending_txns[$];
   presence_type presence_expected[$];

   // Mirror of the block: configuration and filter/debounce state.
   cfg_type          cfg_mirror;
   logic [AVG_W-1:0] avg_mirror;
   logic             blk_passed;
   logic [15:0]      level_mirror;
   logic             detect_mirror;
   logic [31:0]      rise_stamp, fall_stamp;
   logic             rise_armed, fall_armed;

   // Run control and bookkeeping.
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;
   int          hold_seen;
   int          hold_left;
   int          txns_issued   = 0;
   int          rsp_seen      = 0;
   int          fail_count    = 0;
   int          samples_sent  = 0;
   int          polls_sent    = 0;
   int          default_polls = 0;
   int          detect_seen   = 0;
   int          cycle_count   = 0;
   logic [31:0] gen_ms        = 32'd5000;

   adaptive_filter_presence_detector #(
      .FRAC_BITS(FRAC_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .req_now_ms      (req_now_ms),
      .req_rise_timeout(req_rise_timeout),
      .req_fall_timeout(req_fall_timeout),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_level       (rsp_level),
      .rsp_detected    (rsp_detected)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Move the average toward the sample; the step rounds toward minus
   // infinity, which an arithmetic shift of the signed product gives.
   function automatic logic [AVG_W-1:0] ema_next(input logic [AVG_W-1:0] avg,
                                                  input logic [15:0] s);
      longint diff, mag, prod, step, nxt;
      logic [15:0] gain;
      diff = (longint'(s) << FRAC_BITS) - longint'(avg);
      mag  = (diff < 0) ? -diff : diff;
      // large step: distance above 1.5 in fixed point
      gain = (mag > (longint'(3) << (FRAC_BITS - 1))) ? cfg_mirror.gain_high
                                                       : cfg_mirror.gain_low;
      prod = diff * longint'(gain);
      step = prod >>> GAIN_SHIFT;
      nxt  = longint'(avg) + step;
      return nxt[AVG_W-1:0];
   endfunction

   function automatic void drop_timers();
      rise_stamp = '0;
      fall_stamp = '0;
      rise_armed = 1'b0;
      fall_armed = 1'b0;
   endfunction

   // Apply one accepted transaction to the mirror and return the response
   // that the block owes for it.
   function automatic presence_type advance_presence(input req_txn_type t);
      logic [31:0] rise_lim, fall_lim, rise_age, fall_age;
      logic [15:0] thr;
      if (t.op == OP_SAMPLE) begin
         if (t.sample >= MIN_SAMPLE) begin
            avg_mirror = ema_next(avg_mirror, t.sample);
            blk_passed = 1'b1;
         end
         // close the block even when nothing in it passed
         if (t.last) begin
            level_mirror = blk_passed ? avg_mirror[AVG_W-1:FRAC_BITS] : 16'd0;
            blk_passed   = 1'b0;
         end
      end else begin
         // both timeouts zero select the configured defaults
         if (t.rise_timeout == '0 && t.fall_timeout == '0) begin
            rise_lim = cfg_mirror.pulse_time_max + cfg_mirror.rise_extra_time;
            fall_lim = cfg_mirror.fall_timeout_default;
         end else begin
            rise_lim = t.rise_timeout;
            fall_lim = t.fall_timeout;
         end
         thr = cfg_mirror.distance_min + cfg_mirror.trigger_offset;
         if (level_mirror > thr) begin
            if (!detect_mirror) begin
               if (!rise_armed) begin
                  rise_stamp = t.now_ms;
                  rise_armed = 1'b1;
               end
               rise_age = t.now_ms - rise_stamp;
               if (rise_age >= rise_lim) begin
                  detect_mirror = 1'b1;
                  drop_timers();
               end
               fall_armed = 1'b0;
               fall_stamp = '0;
            end else begin
               drop_timers();
            end
         end else if (rise_armed) begin
            if (!fall_armed) begin
               fall_stamp = t.now_ms;
               fall_armed = 1'b1;
            end
            fall_age = t.now_ms - fall_stamp;
            rise_age = t.now_ms - rise_stamp;
            if (fall_age >= fall_lim || rise_age >= rise_lim) begin
               detect_mirror = 1'b0;
               drop_timers();
            end
         end else begin
            detect_mirror = 1'b0;
            drop_timers();
         end
      end
      return '{level: level_mirror, detected: detect_mirror};
   endfunction

   // ---------------------------------------------------------------------
   // Driver: offer pending transactions, predict each one on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_txn_type nxt;
      req_txn_type taken;
      if (reset) begin
         req_valid     <= 1'b0;
         cfg_mirror    = '{gain_high: GAIN_HIGH_RESET, gain_low: GAIN_LOW_RESET,
                           default: '0};
         avg_mirror    = '0;
         blk_passed    = 1'b0;
         level_mirror  = '0;
         detect_mirror = 1'b0;
         rise_stamp    = '0;
         fall_stamp    = '0;
         rise_armed    = 1'b0;
         fall_armed    = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken = '{op: op_type'(req_op), sample: req_sample, last: req_last_sample,
                      now_ms: req_now_ms, rise_timeout: req_rise_timeout,
                      fall_timeout: req_fall_timeout};
            presence_expected.push_back(advance_presence(taken));
            if (taken.op == OP_SAMPLE) begin
               samples_sent++;
            end else begin
               polls_sent++;
               if (taken.rise_timeout == '0 && taken.fall_timeout == '0) begin
                  default_polls++;
               end
            end
         end
         // hold the payload while the block stalls us
         if (!(req_valid && !req_ready)) begin
            if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_txns.pop_front();
               txns_issued++;
               req_valid        <= 1'b1;
               req_op           <= nxt.op;
               req_sample       <= nxt.sample;
               req_last_sample  <= nxt.last;
               req_now_ms       <= nxt.now_ms;
               req_rise_timeout <= nxt.rise_timeout;
               req_fall_timeout <= nxt.fall_timeout;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each response transaction against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      presence_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (rsp_detected) begin
               detect_seen++;
            end
            if (presence_expected.size() == 0) begin
               $display("%0t: response with nothing expected, level %0d detected %0b",
                        $time, rsp_level, rsp_detected);
               fail_count++;
            end else begin
               want = presence_expected.pop_front();
               if (rsp_level !== want.level) begin
                  $display("%0t: level mismatch, expected %0d, actual %0d",
                           $time, want.level, rsp_level);
                  fail_count++;
               end
               if (rsp_detected !== want.detected) begin
                  $display("%0t: detected mismatch, expected %0b, actual %0b",
                           $time, want.detected, rsp_detected);
                  fail_count++;
               end
            end
         end
         // drop ready while a long hold-off runs, otherwise stall at random
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering and
   // the block's queue fills up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Write one register; call right after a rising edge. Valid stays high
   // so back-to-back writes need no bubble; the caller drops it at the end.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_HIGH:       cfg_mirror.gain_high            = data[15:0];
         CSR_GAIN_LOW:        cfg_mirror.gain_low             = data[15:0];
         CSR_DISTANCE_MIN:    cfg_mirror.distance_min         = data[15:0];
         CSR_TRIGGER_OFFSET:  cfg_mirror.trigger_offset       = data[15:0];
         CSR_PULSE_TIME_MAX:  cfg_mirror.pulse_time_max       = data;
         CSR_RISE_EXTRA_TIME: cfg_mirror.rise_extra_time      = data;
         CSR_FALL_TIMEOUT:    cfg_mirror.fall_timeout_default = data;
         default: ;
      endcase
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_GAIN_HIGH, 32'(c.gain_high));
      write_reg(CSR_GAIN_LOW, 32'(c.gain_low));
      write_reg(CSR_DISTANCE_MIN, 32'(c.distance_min));
      write_reg(CSR_TRIGGER_OFFSET, 32'(c.trigger_offset));
      write_reg(CSR_PULSE_TIME_MAX, c.pulse_time_max);
      write_reg(CSR_RISE_EXTRA_TIME, c.rise_extra_time);
      write_reg(CSR_FALL_TIMEOUT, c.fall_timeout_default);
      csr_valid <= 1'b0;
   endtask

   // Unused fields carry random junk; the block must ignore them.
   function automatic void push_sample(input logic [15:0] s, input logic last);
      pending_txns.push_back('{op: OP_SAMPLE, sample: s, last: last, now_ms: $urandom,
                               rise_timeout: $urandom, fall_timeout: $urandom});
   endfunction

   function automatic void push_poll(input logic [31:0] now, input logic [31:0] rt,
                                     input logic [31:0] ft);
      pending_txns.push_back('{op: OP_POLL, sample: 16'($urandom), last: 1'($urandom),
                               now_ms: now, rise_timeout: rt, fall_timeout: ft});
   endfunction

   // Mostly well-formed traffic: a block of samples around a level just
   // above or below the threshold, then a few polls with time moving on.
   // The rest is noise with every field random.
   task automatic queue_random(input int n);
      int made, k, target, r;
      logic [15:0] thr;
      logic [31:0] rt, ft;
      made = 0;
      thr  = cfg_mirror.distance_min + cfg_mirror.trigger_offset;
      while (made < n) begin
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(1) == 1) begin
               target = int'(thr) + int'($urandom_range(1, 400));
            end else begin
               target = int'(thr) - int'($urandom_range(0, 400));
            end
            if (target < 0) target = 0;
            if (target > 65535) target = 65535;
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
               r = target + int'($urandom_range(0, 6)) - 3;
               if (r < 0) r = 0;
               if (r > 65535) r = 65535;
               push_sample(16'(r), i == k - 1);
            end
            made += k;
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
               // occasionally jump the clock, sometimes right before the wrap
               r = $urandom_range(99);
               if (r < 2) begin
                  gen_ms = $urandom;
               end else if (r < 4) begin
                  gen_ms = 32'hFFFF_FFF0 + $urandom_range(0, 12);
               end else begin
                  gen_ms = gen_ms + $urandom_range(0, 8);
               end
               r = $urandom_range(99);
               if (r < 30) begin
                  rt = '0;
                  ft = '0;
               end else if (r < 85) begin
                  rt = $urandom_range(0, 12);
                  ft = $urandom_range(0, 12);
               end else begin
                  rt = $urandom;
                  ft = $urandom;
               end
               push_poll(gen_ms, rt, ft);
            end
            made += k;
         end else begin
            pending_txns.push_back('{op: op_type'($urandom_range(1)),
                                     sample: 16'($urandom), last: 1'($urandom),
                                     now_ms: $urandom,
                                     rise_timeout: $urandom, fall_timeout: $urandom});
            made++;
         end
      end
   endtask

   // Wait until every issued transaction has its response, then let the
   // pipeline settle before touching registers again.
   task automatic wait_drained();
      while (pending_txns.size() != 0 || rsp_seen < txns_issued) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 1: directed, threshold 500, default rise 15 ms, fall 7 ms.
      send_idle_pct = 29;
      recv_idle_pct = 77;
      program_regs('{gain_high: 16'd36045, gain_low: 16'd9830, distance_min: 16'd300,
                     trigger_offset: 16'd200, pulse_time_max: 32'd10,
                     rise_extra_time: 32'd5, fall_timeout_default: 32'd7});
      push_sample(16'd0, 1'b0);          // small sample, ignored by the filter
      push_sample(16'hFFFF, 1'b0);       // full-scale, large step
      push_sample(16'hFFFF, 1'b1);       // close block, level near full scale
      push_sample(16'd99, 1'b1);         // block with nothing passing: level 0
      push_sample(16'd100, 1'b1);        // smallest passing sample
      push_sample(16'd101, 1'b0);
      push_sample(16'd101, 1'b1);
      push_poll(32'd1000, '0, '0);       // default timeouts, rise timer starts
      push_poll(32'd1010, '0, '0);
      push_poll(32'd1015, '0, '0);       // rise timeout reached: detect
      push_poll(32'd1020, '0, '0);       // still above with detect: timers clear
      push_sample(16'd50, 1'b1);         // level drops to 0
      push_poll(32'd1021, '0, '0);       // below, no rise running: detect clears
      push_sample(16'd60000, 1'b1);
      push_poll(32'hFFFF_FFF8, 32'd100, 32'd3);  // rise starts just before wrap
      push_sample(16'd10, 1'b1);
      push_poll(32'hFFFF_FFFE, 32'd100, 32'd3);  // fall timer starts
      push_poll(32'h0000_0001, 32'd100, 32'd3);  // fall expires across the wrap
      push_sample(16'hFFFF, 1'b1);
      push_poll(32'd0, '0, 32'd5);       // explicit zero rise timeout: instant
      push_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_poll(32'd40, 32'hFFFF_FFFF, '0);      // detected, above: clear timers
      push_sample(16'd20, 1'b1);
      push_poll(32'd41, 32'd20, 32'd50);
      wait_drained();

      // Phase 2: extreme gains, wrapped threshold and wrapped default rise.
      program_regs('{gain_high: 16'hFFFF, gain_low: 16'h0000, distance_min: 16'hFFFF,
                     trigger_offset: 16'd2001, pulse_time_max: 32'hFFFF_FFF8,
                     rise_extra_time: 32'h0000_0010, fall_timeout_default: 32'hFFFF_FFFF});
      queue_random(PHASE_ITEMS);
      wait_drained();

      // Phase 3: swap the idle mix, frozen large steps, zero threshold.
      send_idle_pct = 77;
      recv_idle_pct = 29;
      program_regs('{gain_high: 16'h0000, gain_low: 16'hFFFF, distance_min: 16'd0,
                     trigger_offset: 16'd0, pulse_time_max: 32'd0,
                     rise_extra_time: 32'd0, fall_timeout_default: 32'd0});
      queue_random(PHASE_ITEMS);
      wait_drained();

      // Phase 4: no idling; open with a long hold-off so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs('{gain_high: GAIN_HIGH_RESET, gain_low: GAIN_LOW_RESET,
                     distance_min: 16'd1200, trigger_offset: 16'd34,
                     pulse_time_max: 32'd3, rise_extra_time: 32'd4,
                     fall_timeout_default: 32'd6});
      queue_random(PHASE_ITEMS);
      hold_requests++;
      wait_drained();

      if (presence_expected.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, presence_expected.size());
         fail_count++;
      end
      $display("Covered %0d sample and %0d poll transactions (%0d with default timeouts),",
               samples_sent, polls_sent, default_polls);
      $display("%0d responses checked, %0d with presence set, over four register settings.",
               rsp_seen, detect_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/afpd_pkg.sv
rtl/afpd_front.sv
rtl/afpd_queue.sv
rtl/afpd_back.sv
rtl/adaptive_filter_presence_detector.sv
dv/adaptive_filter_presence_detector_tb.sv
